// File: hw/rtl/srad_pkg.sv
// Shared types, constants and helpers for the sensor record ASCII serializer.
// Depends on nothing.
package srad_pkg;
	localparam int NumValues = 6;
	localparam int ValueWidth = 16;
	localparam int MagWidth = 16;
	localparam int DigitCount = 5;
	localparam logic [7:0] ChD = 8'h44;
	localparam logic [7:0] ChS = 8'h53;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChNewline = 8'h0a;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero = 8'h30;

	typedef logic [3:0] digit_t;
	typedef digit_t [DigitCount-1:0] digits_t;

	// Per value: sign, digits (index 4 most significant), count of digits.
	typedef struct packed {
		logic neg;
		digits_t dig;
		logic [2:0] nd;
	} dec_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SPACE,
		PH_MINUS,
		PH_DIGIT,
		PH_NEWLINE
	} phase_t;

	// Quotient by ten of a value below 65536, by reciprocal multiply.
	function automatic logic [MagWidth-1:0] div10(input logic [MagWidth-1:0] v);
		logic [MagWidth+19:0] p;
		begin
			p = {20'd0, v} * 36'd52429;
			div10 = p[MagWidth+18:19];
		end
	endfunction
endpackage

// File: hw/rtl/sensor_record_to_ascii_decimal.sv
// Top level of the sensor record ASCII decimal serializer.
// Depends on srad_pkg and srad_digit_pipe.
// Throughput: one output beat per cycle while out_ready is high; a record is
// 14 to 44 bytes long, set by the byte serializer. The digit pipeline fills
// behind it, so records follow one another with no gap.
// Reset: arst_n clears all valid bits and the serializer state.
module sensor_record_to_ascii_decimal (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic record_kind,
	input  logic signed [15:0] value_one,
	input  logic signed [15:0] value_two,
	input  logic signed [15:0] value_three,
	input  logic signed [15:0] value_four,
	input  logic signed [15:0] value_five,
	input  logic signed [15:0] value_six,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] ascii_char,
	output logic last_char
);
	import srad_pkg::*;

	logic [NumValues-1:0][ValueWidth-1:0] vals;
	logic cv_valid;
	logic cv_ready;
	logic cv_kind;
	dec_t [NumValues-1:0] cv_dec;

	assign vals = {value_six, value_five, value_four, value_three, value_two,
		value_one};

	// The converter yields sign and digit count for every value in parallel.
	srad_digit_pipe u_pipe (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_kind(record_kind), .in_vals(vals),
		.out_valid(cv_valid), .out_ready(cv_ready),
		.out_kind(cv_kind), .out_dec(cv_dec)
	);

	// The serializer walks the converted record one byte per beat. It holds
	// the phase, the value index and the digit position.
	phase_t ph_q, ph_d;
	logic [2:0] vi_q, vi_d;
	logic [2:0] di_q, di_d;
	dec_t cur;
	logic fire;
	logic [7:0] ch;

	assign cur = cv_dec[vi_q];
	assign fire = cv_valid && out_ready;
	assign out_valid = cv_valid;
	assign ascii_char = ch;
	assign last_char = (ph_q == PH_NEWLINE);
	assign cv_ready = out_ready && (ph_q == PH_NEWLINE);

	always_comb begin
		ph_d = ph_q;
		vi_d = vi_q;
		di_d = di_q;
		ch = ChNewline;
		unique case (ph_q)
			PH_LEAD: begin
				ch = cv_kind ? ChS : ChD;
				ph_d = PH_SPACE;
				vi_d = '0;
			end
			PH_SPACE: begin
				ch = ChSpace;
				ph_d = cur.neg ? PH_MINUS : PH_DIGIT;
				di_d = cur.nd - 3'd1;
			end
			PH_MINUS: begin
				ch = ChMinus;
				ph_d = PH_DIGIT;
			end
			PH_DIGIT: begin
				ch = ChZero + {4'd0, cur.dig[di_q]};
				if (di_q == 3'd0) begin
					if (vi_q == 3'(NumValues - 1)) begin
						ph_d = PH_NEWLINE;
					end else begin
						vi_d = vi_q + 3'd1;
						ph_d = PH_SPACE;
					end
				end else begin
					di_d = di_q - 3'd1;
				end
			end
			PH_NEWLINE: begin
				ch = ChNewline;
				ph_d = PH_LEAD;
			end
			default: ph_d = PH_LEAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LEAD;
			vi_q <= '0;
			di_q <= '0;
		end else if (fire) begin
			ph_q <= ph_d;
			vi_q <= vi_d;
			di_q <= di_d;
		end
	end

	a_last_only_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> ascii_char == ChNewline)
		else $error("last beat is not a newline");
	a_lead_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_char |=> ph_q == PH_LEAD)
		else $error("record did not restart with its lead byte");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		vi_q < 3'(NumValues) && di_q < 3'(DigitCount))
		else $error("serializer index out of range");
endmodule

// File: hw/rtl/srad_digit_pipe.sv
// Pipelined binary to decimal converter for the six record values.
// Depends on srad_pkg; a magnitude stage, then five stages that peel one digit each.
module srad_digit_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_kind,
	input  logic [srad_pkg::NumValues-1:0][srad_pkg::ValueWidth-1:0] in_vals,
	output logic out_valid,
	input  logic out_ready,
	output logic out_kind,
	output srad_pkg::dec_t [srad_pkg::NumValues-1:0] out_dec
);
	import srad_pkg::*;

	localparam int Stages = DigitCount + 1;

	logic [Stages-1:0] vld_s;
	logic [Stages-1:0] kind_s;
	logic [Stages-1:0][NumValues-1:0][MagWidth-1:0] mag_s;
	dec_t [Stages-1:0][NumValues-1:0] dec_s;
	logic [Stages-1:0] adv;

	// A stage advances when it is empty or its content moves on.
	always_comb begin
		adv[Stages-1] = !vld_s[Stages-1] || out_ready;
		for (int i = Stages - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end
	assign in_ready = adv[0];
	assign out_valid = vld_s[Stages-1];
	assign out_kind = kind_s[Stages-1];
	assign out_dec = dec_s[Stages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < Stages; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Stage zero takes the magnitude; later stages each produce one digit.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			kind_s[0] <= in_kind;
			for (int v = 0; v < NumValues; v++) begin
				dec_t d0;
				d0 = '0;
				d0.neg = in_vals[v][ValueWidth-1];
				dec_s[0][v] <= d0;
				mag_s[0][v] <= in_vals[v][ValueWidth-1] ? (~in_vals[v] + 16'd1) : in_vals[v];
			end
		end
		for (int i = 1; i < Stages; i++) begin
			if (adv[i]) begin
				kind_s[i] <= kind_s[i-1];
				for (int v = 0; v < NumValues; v++) begin
					logic [MagWidth-1:0] q;
					logic [MagWidth-1:0] r;
					dec_t dn;
					q = div10(mag_s[i-1][v]);
					r = mag_s[i-1][v] - ((q << 3) + (q << 1));
					dn = dec_s[i-1][v];
					dn.dig[i-1] = r[3:0];
					if (mag_s[i-1][v] != '0 || i == 1) dn.nd = 3'(i);
					mag_s[i][v] <= q;
					dec_s[i][v] <= dn;
				end
			end
		end
	end

	a_digits_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_dec[0].nd != 3'd0)
		else $error("value with no digits");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dec))
		else $error("converted record changed under stall");
	a_top_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_dec[0].nd > 3'd1 |-> out_dec[0].dig[out_dec[0].nd - 3'd1] != 4'd0)
		else $error("leading zero digit");
endmodule

// File: tb/tb_sensor_record_to_ascii_decimal.sv
// Self-checking testbench for sensor_record_to_ascii_decimal.
// Depends on srad_pkg and the serializer RTL; predicts every output beat of a
// record and compares the byte stream beat by beat under random idling.
`timescale 1ns / 1ps

module tb_sensor_record_to_ascii_decimal;
	import srad_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
	} text_beat_t;

	localparam int IdleLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic record_kind = 1'b0;
	logic signed [15:0] value_one = '0;
	logic signed [15:0] value_two = '0;
	logic signed [15:0] value_three = '0;
	logic signed [15:0] value_four = '0;
	logic signed [15:0] value_five = '0;
	logic signed [15:0] value_six = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] ascii_char;
	logic last_char;

	// Bytes still owed by the block, oldest first.
	text_beat_t pending_text[$];
	int error_count = 0;
	int idle_cycles = 0;
	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;

	sensor_record_to_ascii_decimal i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.record_kind(record_kind),
		.value_one(value_one),
		.value_two(value_two),
		.value_three(value_three),
		.value_four(value_four),
		.value_five(value_five),
		.value_six(value_six),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ascii_char(ascii_char),
		.last_char(last_char)
	);

	always #6 clk = ~clk;

	// Appends the decimal text of one value: sign, then digits without
	// leading zeros. The magnitude is taken in 17 bits so that the most
	// negative value prints in full.
	task automatic push_decimal(input logic [15:0] raw);
		logic [16:0] mag;
		logic [7:0] digs[$];
		begin
			if (raw[15]) begin
				pending_text.push_back('{ChMinus, 1'b0});
				mag = 17'h10000 - {1'b0, raw};
			end else begin
				mag = {1'b0, raw};
			end
			if (mag == 0) begin
				pending_text.push_back('{ChZero, 1'b0});
			end else begin
				while (mag != 0) begin
					digs.push_front(ChZero + 8'(mag % 10));
					mag = mag / 10;
				end
				foreach (digs[i]) pending_text.push_back('{digs[i], 1'b0});
			end
		end
	endtask

	// Forms the expected text of one record.
	task automatic predict_record(input logic kind, input logic [15:0] vals[6]);
		begin
			pending_text.push_back('{kind ? ChS : ChD, 1'b0});
			for (int k = 0; k < NumValues; k++) begin
				pending_text.push_back('{ChSpace, 1'b0});
				push_decimal(vals[k]);
			end
			pending_text.push_back('{ChNewline, 1'b1});
		end
	endtask

	// Offers one record and holds it until the beat is taken. Valid stays
	// high straight into the next record when no idle cycle is drawn.
	task automatic send_record(input logic kind, input logic [15:0] vals[6]);
		begin
			if (!steady) begin
				while ($urandom_range(99) < 28) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			in_valid <= 1'b1;
			record_kind <= kind;
			value_one <= vals[0];
			value_two <= vals[1];
			value_three <= vals[2];
			value_four <= vals[3];
			value_five <= vals[4];
			value_six <= vals[5];
			predict_record(kind, vals);
			do @(posedge clk); while (!in_ready);
		end
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(20)) - 10);
			3: return '0;
			4: return 16'(int'($urandom_range(2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	// Every special case: extremes of each field, zero, minus one and
	// the most negative value written in full.
	task automatic test_extremes();
		logic [15:0] vals[6];
		logic [15:0] picks[10] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
			16'h8001, 16'd9, 16'd10, 16'hfff6, 16'd9999};
		begin
			for (int n = 0; n < 16; n++) begin
				for (int k = 0; k < NumValues; k++) vals[k] = picks[(n + k) % 10];
				send_record(n[0], vals);
			end
			for (int k = 0; k < NumValues; k++) vals[k] = 16'h8000;
			send_record(1'b0, vals);
			send_record(1'b1, vals);
		end
	endtask

	task automatic test_random(input int count);
		logic [15:0] vals[6];
		begin
			for (int n = 0; n < count; n++) begin
				for (int k = 0; k < NumValues; k++) vals[k] = pick_value();
				send_record(1'(($urandom)), vals);
			end
		end
	endtask

	// A burst with no idling on either side checks back-to-back records.
	task automatic test_back_to_back(input int count);
		begin
			steady = 1'b1;
			test_random(count);
			steady = 1'b0;
		end
	endtask

	// Receiver: stalls at random and checks every accepted beat.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected beat char=%h last=%b", $time, ascii_char,
					last_char);
				error_count++;
			end else begin
				text_beat_t exp_beat;
				exp_beat = pending_text.pop_front();
				if (ascii_char !== exp_beat.ch) begin
					$display("%0t: ascii_char expected %h actual %h", $time, exp_beat.ch,
						ascii_char);
					error_count++;
				end
				if (last_char !== exp_beat.last) begin
					$display("%0t: last_char expected %b actual %b", $time, exp_beat.last,
						last_char);
					error_count++;
				end
			end
		end
		if (arst_n) out_ready <= steady || ($urandom_range(99) >= 28);
	end

	// Watchdog on cycles where no beat moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("sensor_record_to_ascii_decimal regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(90);
		test_back_to_back(40);
		test_random(70);
		in_valid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0) begin
			$display("sensor_record_to_ascii_decimal regression: pass");
		end else begin
			$display("sensor_record_to_ascii_decimal regression: fail");
		end
		$finish;
	end
endmodule
